// ===== rtl/tnpf_pkg.sv =====
// shared constants, codes and payload types of the tetrahedral flux core
`default_nettype none
package tnpf_pkg;

	// default mesh capacity
	localparam int MAX_NODES_DEF    = 1024;
	localparam int MAX_ELEMENTS_DEF = 4096;
	localparam int CORNERS          = 4;
	localparam int CORNER_W         = 2;

	// request kinds
	localparam logic [2:0] KIND_NODE    = 3'd0;
	localparam logic [2:0] KIND_CORNER  = 3'd1;
	localparam logic [2:0] KIND_VOLUME  = 3'd2;
	localparam logic [2:0] KIND_COMPUTE = 3'd3;
	localparam logic [2:0] KIND_READ    = 3'd4;

	// register indexes
	localparam logic [1:0] REG_DIFFUSION     = 2'd0;
	localparam logic [1:0] REG_VALENCE       = 2'd1;
	localparam logic [1:0] REG_NODE_COUNT    = 2'd2;
	localparam logic [1:0] REG_ELEMENT_COUNT = 2'd3;

	// register reset values
	localparam logic [31:0] DIFFUSION_RESET     = 32'h0001_0000;
	localparam logic [4:0]  VALENCE_RESET       = 5'd1;
	localparam logic [10:0] NODE_COUNT_RESET    = 11'd1024;
	localparam logic [12:0] ELEMENT_COUNT_RESET = 13'd4096;

	typedef struct packed {
		logic [2:0]         kind;
		logic [11:0]        item_index;
		logic [1:0]         corner;
		logic [9:0]         corner_node;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
	} in_item_t;

	typedef struct packed {
		logic               is_flux;
		logic [9:0]         node_out;
		logic signed [31:0] flux_x;
		logic signed [31:0] flux_y;
		logic signed [31:0] flux_z;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] value;
	} cfg_req_t;

endpackage
`default_nettype wire

// ===== rtl/tnpf_ifs.sv =====
// valid/ready channel interfaces of the tetrahedral flux core
`default_nettype none
interface tnpf_in_if;
	import tnpf_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tnpf_out_if;
	import tnpf_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tnpf_cfg_if;
	import tnpf_pkg::*;
	logic     valid;
	logic     ready;
	cfg_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tet_mesh_nernst_planck_flux_core.sv =====
// Nernst-Planck flux core: mesh memories, gradient recovery and flux sequencer
//
// Channels: items takes load, compute and read requests; results returns one
// item per compute (acknowledgement, is_flux 0) and per read (is_flux 1);
// regs writes the four configuration registers, always ready; the user must
// write them only while idle; the block does not enforce it. Load requests
// give no result; a read returns data from the flux memory's registered port.
// A compute runs a small sequencer around one shared 33x33 multiplier and a
// one-bit-a-step divider: it clears the accumulators of every node, then
// per element gathers four corners, six products each, then six
// volume-weighted products per corner scattered by read-modify-write, and
// per node runs six 32-step divisions and three flux products.
// items is not ready while a compute or read is in progress, nor while a
// result waits that is not being taken; results holds its item until taken.
// Reset restores the register defaults and empties the result register;
// node, element and flux memories hold nothing defined until written.
`default_nettype none
module tet_mesh_nernst_planck_flux_core #(
	parameter int MAX_NODES    = tnpf_pkg::MAX_NODES_DEF,
	parameter int MAX_ELEMENTS = tnpf_pkg::MAX_ELEMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tnpf_in_if.sink     items,
	tnpf_out_if.source  results,
	tnpf_cfg_if.sink    regs
);
	import tnpf_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int ELEM_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int SLOT_W = ELEM_W + CORNER_W;
	localparam int NCNT_W = $clog2(MAX_NODES + 1);
	localparam int ECNT_W = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [28:0] {
		ST_IDLE   = 29'd1 << 0,
		ST_RD     = 29'd1 << 1,
		ST_CLR    = 29'd1 << 2,
		ST_E_RDC  = 29'd1 << 3,
		ST_E_RDN  = 29'd1 << 4,
		ST_E_CV   = 29'd1 << 5,
		ST_E_MUL  = 29'd1 << 6,
		ST_E_ACC  = 29'd1 << 7,
		ST_E_SAT  = 29'd1 << 8,
		ST_F_RDC  = 29'd1 << 9,
		ST_F_RDA  = 29'd1 << 10,
		ST_F_LAT  = 29'd1 << 11,
		ST_F_MUL  = 29'd1 << 12,
		ST_F_ACC  = 29'd1 << 13,
		ST_F_WR   = 29'd1 << 14,
		ST_F_NEXT = 29'd1 << 15,
		ST_N_RD   = 29'd1 << 16,
		ST_N_LAT  = 29'd1 << 17,
		ST_N_DIVS = 29'd1 << 18,
		ST_N_DIV  = 29'd1 << 19,
		ST_N_DIVE = 29'd1 << 20,
		ST_X_MUL  = 29'd1 << 21,
		ST_X_ZT   = 29'd1 << 22,
		ST_X_S    = 29'd1 << 23,
		ST_X_MLO  = 29'd1 << 24,
		ST_X_MHI  = 29'd1 << 25,
		ST_X_FIN  = 29'd1 << 26,
		ST_N_WR   = 29'd1 << 27,
		ST_ACK    = 29'd1 << 28
	} state_t;

	// saturate a wide signed sum to 32 bits
	function automatic logic signed [31:0] sat50(input logic signed [49:0] x);
		logic signed [31:0] r;
		if (x > 50'sd2147483647) r = 32'h7FFF_FFFF;
		else if (x < -50'sd2147483648) r = 32'h8000_0000;
		else r = x[31:0];
		return r;
	endfunction

	// magnitude and sign to saturated 32-bit value
	function automatic logic signed [31:0] ssat(input logic [63:0] m, input logic neg);
		logic signed [31:0] r;
		if (neg) r = (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
		else r = (m >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		return r;
	endfunction

	// control state
	state_t              state_q;
	logic                out_valid_q;
	logic [31:0]         diff_q;
	logic signed [4:0]   val_q;
	logic [10:0]         ncnt_q;
	logic [12:0]         ecnt_q;
	logic [NCNT_W-1:0]   nn_q;
	logic [NCNT_W-1:0]   n_q;
	logic [ECNT_W-1:0]   ne_q;
	logic [ECNT_W-1:0]   e_q;
	logic [1:0]          k_q;
	logic [2:0]          j_q;
	logic [1:0]          d_q;
	logic [5:0]          div_cnt_q;

	// datapath registers
	out_item_t           out_q;
	logic [11:0]         rd_idx_q;
	logic                rd_ok_q;
	logic signed [31:0]  g_q [3];
	logic signed [31:0]  vol_q;
	logic signed [31:0]  cv_q;
	logic signed [31:0]  pv_q;
	logic signed [31:0]  c_q;
	logic signed [49:0]  gacc_q [6];
	logic signed [31:0]  gsat_q [6];
	logic [9:0]          nd_q;
	logic [63:0]         acc_q [6];
	logic [47:0]         w_q;
	logic signed [65:0]  prod_q;
	logic [65:0]         plo_q;
	logic                dneg_q;
	logic [31:0]         q_q;
	logic [47:0]         rem_q;
	logic [31:0]         nlo_q;
	logic signed [31:0]  gn_q [6];
	logic signed [52:0]  zt_q;
	logic [53:0]         mag_q;
	logic                spos_q;
	logic signed [31:0]  fl_q [3];

	// memories and their registered read data
	logic signed [31:0]  conc_mem [MAX_NODES];
	logic signed [31:0]  pot_mem [MAX_NODES];
	logic [9:0]          cn_mem [CORNERS*MAX_ELEMENTS];
	logic signed [31:0]  gx_mem [CORNERS*MAX_ELEMENTS];
	logic signed [31:0]  gy_mem [CORNERS*MAX_ELEMENTS];
	logic signed [31:0]  gz_mem [CORNERS*MAX_ELEMENTS];
	logic signed [31:0]  vol_mem [MAX_ELEMENTS];
	logic [2:0][63:0]    accc_mem [MAX_NODES];
	logic [2:0][63:0]    accp_mem [MAX_NODES];
	logic [47:0]         accw_mem [MAX_NODES];
	logic [2:0][31:0]    flux_mem [MAX_NODES];

	logic signed [31:0]  conc_rd_q;
	logic signed [31:0]  pot_rd_q;
	logic [9:0]          cn_rd_q;
	logic signed [31:0]  gx_rd_q;
	logic signed [31:0]  gy_rd_q;
	logic signed [31:0]  gz_rd_q;
	logic signed [31:0]  vol_rd_q;
	logic [2:0][63:0]    accc_rd_q;
	logic [2:0][63:0]    accp_rd_q;
	logic [47:0]         accw_rd_q;
	logic [2:0][31:0]    flux_rd_q;

	// combinational signals
	logic                in_acc;
	logic                node_ok;
	logic                elem_ok;
	logic                nd_ok;
	logic                n_ok;
	logic [NCNT_W-1:0]   nn_d;
	logic [ECNT_W-1:0]   ne_d;
	logic [NODE_W-1:0]   node_raddr;
	logic [SLOT_W-1:0]   slot_raddr;
	logic [SLOT_W-1:0]   slot_waddr;
	logic                acc_we;
	logic [NODE_W-1:0]   acc_waddr;
	logic [2:0][63:0]    accc_wd;
	logic [2:0][63:0]    accp_wd;
	logic [47:0]         accw_wd;
	logic [1:0]          dim;
	logic signed [32:0]  mul_a;
	logic signed [32:0]  mul_b;
	logic signed [65:0]  mul_p;
	logic [63:0]         div_a;
	logic [63:0]         div_mag;
	logic                w_pos;
	logic                div_ovf;
	logic [48:0]         r2;
	logic                r_ge;
	logic [48:0]         r_diff;
	logic signed [52:0]  zt_d;
	logic signed [53:0]  s_d;
	logic [79:0]         m80;
	logic signed [31:0]  fin_d;

	// handshakes and range checks
	assign in_acc  = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE) && (!out_valid_q || results.ready);
	assign regs.ready  = 1'b1;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;
	assign node_ok = 32'(items.data.item_index) < 32'(MAX_NODES);
	assign elem_ok = 32'(items.data.item_index) < 32'(MAX_ELEMENTS);
	assign nd_ok   = 32'(cn_rd_q) < 32'(nn_q);
	assign n_ok    = n_q < nn_q;
	assign nn_d = (32'(ncnt_q) > 32'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : NCNT_W'(ncnt_q);
	assign ne_d = (32'(ecnt_q) > 32'(MAX_ELEMENTS)) ? ECNT_W'(MAX_ELEMENTS) : ECNT_W'(ecnt_q);

	// memory addressing
	assign node_raddr = (state_q == ST_E_RDN || state_q == ST_F_RDA) ? NODE_W'(cn_rd_q)
		: n_q[NODE_W-1:0];
	assign slot_raddr = {e_q[ELEM_W-1:0], k_q};
	assign slot_waddr = {ELEM_W'(items.data.item_index), items.data.corner};
	assign acc_we    = (state_q == ST_CLR && n_ok) || state_q == ST_F_WR;
	assign acc_waddr = (state_q == ST_CLR) ? n_q[NODE_W-1:0] : NODE_W'(nd_q);

	always_comb begin
		if (state_q == ST_CLR) begin
			accc_wd = '0;
			accp_wd = '0;
			accw_wd = '0;
		end else begin
			accc_wd = {acc_q[2], acc_q[1], acc_q[0]};
			accp_wd = {acc_q[5], acc_q[4], acc_q[3]};
			accw_wd = w_q;
		end
	end

	// node memories
	always_ff @(posedge clk) begin
		if (in_acc && items.data.kind == KIND_NODE && node_ok) begin
			conc_mem[NODE_W'(items.data.item_index)] <= items.data.value_a;
			pot_mem[NODE_W'(items.data.item_index)]  <= items.data.value_b;
		end
		conc_rd_q <= conc_mem[node_raddr];
		pot_rd_q  <= pot_mem[node_raddr];
	end

	// element corner and volume memories
	always_ff @(posedge clk) begin
		if (in_acc && items.data.kind == KIND_CORNER && elem_ok) begin
			cn_mem[slot_waddr] <= items.data.corner_node;
			gx_mem[slot_waddr] <= items.data.value_a;
			gy_mem[slot_waddr] <= items.data.value_b;
			gz_mem[slot_waddr] <= items.data.value_c;
		end
		if (in_acc && items.data.kind == KIND_VOLUME && elem_ok) begin
			vol_mem[ELEM_W'(items.data.item_index)] <= items.data.value_a;
		end
		cn_rd_q  <= cn_mem[slot_raddr];
		gx_rd_q  <= gx_mem[slot_raddr];
		gy_rd_q  <= gy_mem[slot_raddr];
		gz_rd_q  <= gz_mem[slot_raddr];
		vol_rd_q <= vol_mem[e_q[ELEM_W-1:0]];
	end

	// per-node accumulators
	always_ff @(posedge clk) begin
		if (acc_we) begin
			accc_mem[acc_waddr] <= accc_wd;
			accp_mem[acc_waddr] <= accp_wd;
			accw_mem[acc_waddr] <= accw_wd;
		end
		accc_rd_q <= accc_mem[node_raddr];
		accp_rd_q <= accp_mem[node_raddr];
		accw_rd_q <= accw_mem[node_raddr];
	end

	// flux memory
	always_ff @(posedge clk) begin
		if (state_q == ST_N_WR) begin
			flux_mem[n_q[NODE_W-1:0]] <= {fl_q[2], fl_q[1], fl_q[0]};
		end
		flux_rd_q <= flux_mem[NODE_W'(items.data.item_index)];
	end

	// shared multiplier operand selection
	assign dim = (j_q < 3'd3) ? j_q[1:0] : 2'(j_q - 3'd3);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_E_MUL: begin
				mul_a = (j_q < 3'd3) ? 33'(cv_q) : 33'(pv_q);
				mul_b = 33'(g_q[dim]);
			end
			ST_F_MUL: begin
				mul_a = 33'(vol_q);
				mul_b = 33'(gsat_q[j_q]);
			end
			ST_X_MUL: begin
				mul_a = 33'(c_q);
				mul_b = 33'(gn_q[3'(d_q) + 3'd3]);
			end
			ST_X_MLO: begin
				mul_a = {9'd0, mag_q[23:0]};
				mul_b = {1'b0, diff_q};
			end
			ST_X_MHI: begin
				mul_a = {10'd0, mag_q[46:24]};
				mul_b = {1'b0, diff_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// divider set-up and restoring step
	assign div_a   = acc_q[j_q];
	assign div_mag = div_a[63] ? (64'd0 - div_a) : div_a;
	assign w_pos   = !w_q[47] && (w_q != 48'd0);
	assign div_ovf = div_mag >= {2'b00, w_q[46:0], 15'd0};
	assign r2      = {rem_q, nlo_q[31]};
	assign r_ge    = r2 >= {1'b0, w_q};
	assign r_diff  = r2 - {1'b0, w_q};

	// flux arithmetic
	assign zt_d = val_q * $signed(prod_q[63:16]);
	assign s_d  = 54'(gn_q[3'(d_q)]) + 54'(zt_q);
	assign m80  = {prod_q[55:0], 24'd0} + {24'd0, plo_q[55:0]};

	always_comb begin
		if (diff_q == 32'd0 || mag_q == 54'd0) fin_d = '0;
		else if (|mag_q[53:47]) fin_d = ssat(64'h8000_0000, spos_q);
		else fin_d = ssat(m80[79:16], spos_q);
	end

	// sequencer, counters and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			diff_q      <= DIFFUSION_RESET;
			val_q       <= VALENCE_RESET;
			ncnt_q      <= NODE_COUNT_RESET;
			ecnt_q      <= ELEMENT_COUNT_RESET;
			nn_q        <= '0;
			n_q         <= '0;
			ne_q        <= '0;
			e_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			d_q         <= '0;
			div_cnt_q   <= '0;
		end else begin
			// configuration writes
			if (regs.valid) begin
				case (regs.data.index)
					REG_DIFFUSION:     diff_q <= regs.data.value;
					REG_VALENCE:       val_q  <= regs.data.value[4:0];
					REG_NODE_COUNT:    ncnt_q <= regs.data.value[10:0];
					REG_ELEMENT_COUNT: ecnt_q <= regs.data.value[12:0];
					default: ;
				endcase
			end

			// result register
			if (state_q == ST_RD || state_q == ST_ACK) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && items.data.kind == KIND_COMPUTE) begin
						nn_q    <= nn_d;
						ne_q    <= ne_d;
						n_q     <= '0;
						state_q <= ST_CLR;
					end else if (in_acc && items.data.kind == KIND_READ) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_IDLE;
				ST_CLR: begin
					if (n_ok) begin
						n_q <= n_q + 1'b1;
					end else begin
						n_q     <= '0;
						e_q     <= '0;
						k_q     <= '0;
						state_q <= (ne_q != '0) ? ST_E_RDC : ST_N_RD;
					end
				end
				ST_E_RDC: state_q <= ST_E_RDN;
				ST_E_RDN: state_q <= ST_E_CV;
				ST_E_CV: begin
					j_q     <= '0;
					state_q <= ST_E_MUL;
				end
				ST_E_MUL: state_q <= ST_E_ACC;
				ST_E_ACC: begin
					if (j_q == 3'd5) begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? ST_E_SAT : ST_E_RDC;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_E_MUL;
					end
				end
				ST_E_SAT: state_q <= ST_F_RDC;
				ST_F_RDC: state_q <= ST_F_RDA;
				ST_F_RDA: state_q <= nd_ok ? ST_F_LAT : ST_F_NEXT;
				ST_F_LAT: begin
					j_q     <= '0;
					state_q <= ST_F_MUL;
				end
				ST_F_MUL: state_q <= ST_F_ACC;
				ST_F_ACC: begin
					if (j_q == 3'd5) begin
						state_q <= ST_F_WR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_F_MUL;
					end
				end
				ST_F_WR: state_q <= ST_F_NEXT;
				ST_F_NEXT: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						e_q <= e_q + 1'b1;
						if (ECNT_W'(e_q + 1'b1) == ne_q) begin
							n_q     <= '0;
							state_q <= ST_N_RD;
						end else begin
							state_q <= ST_E_RDC;
						end
					end else begin
						state_q <= ST_F_RDC;
					end
				end
				ST_N_RD: state_q <= n_ok ? ST_N_LAT : ST_ACK;
				ST_N_LAT: begin
					j_q     <= '0;
					state_q <= ST_N_DIVS;
				end
				ST_N_DIVS: begin
					if (w_pos && !div_ovf) begin
						div_cnt_q <= 6'd32;
						state_q   <= ST_N_DIV;
					end else begin
						state_q <= ST_N_DIVE;
					end
				end
				ST_N_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == 6'd1) state_q <= ST_N_DIVE;
				end
				ST_N_DIVE: begin
					if (j_q == 3'd5) begin
						d_q     <= '0;
						state_q <= ST_X_MUL;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_N_DIVS;
					end
				end
				ST_X_MUL: state_q <= ST_X_ZT;
				ST_X_ZT:  state_q <= ST_X_S;
				ST_X_S:   state_q <= ST_X_MLO;
				ST_X_MLO: state_q <= ST_X_MHI;
				ST_X_MHI: state_q <= ST_X_FIN;
				ST_X_FIN: begin
					if (d_q == 2'd2) begin
						state_q <= ST_N_WR;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= ST_X_MUL;
					end
				end
				ST_N_WR: begin
					n_q     <= n_q + 1'b1;
					state_q <= ST_N_RD;
				end
				ST_ACK: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rd_idx_q <= items.data.item_index;
				rd_ok_q  <= node_ok;
			end
			ST_RD: begin
				out_q.is_flux  <= 1'b1;
				out_q.node_out <= rd_idx_q[9:0];
				out_q.flux_x   <= rd_ok_q ? flux_rd_q[0] : 32'sd0;
				out_q.flux_y   <= rd_ok_q ? flux_rd_q[1] : 32'sd0;
				out_q.flux_z   <= rd_ok_q ? flux_rd_q[2] : 32'sd0;
			end
			ST_E_RDN: begin
				g_q[0] <= gx_rd_q;
				g_q[1] <= gy_rd_q;
				g_q[2] <= gz_rd_q;
				vol_q  <= vol_rd_q;
			end
			ST_E_CV: begin
				cv_q <= nd_ok ? conc_rd_q : 32'sd0;
				pv_q <= nd_ok ? pot_rd_q : 32'sd0;
				if (k_q == 2'd0) begin
					for (int i = 0; i < 6; i++) gacc_q[i] <= '0;
				end
			end
			ST_E_MUL, ST_F_MUL, ST_X_MUL, ST_X_MLO: prod_q <= mul_p;
			ST_X_MHI: begin
				plo_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_E_ACC: gacc_q[j_q] <= gacc_q[j_q] + 50'($signed(prod_q[63:16]));
			ST_E_SAT: begin
				for (int i = 0; i < 6; i++) gsat_q[i] <= sat50(gacc_q[i]);
			end
			ST_F_RDA: nd_q <= cn_rd_q;
			ST_F_LAT: begin
				for (int i = 0; i < 3; i++) begin
					acc_q[i]     <= accc_rd_q[i];
					acc_q[i + 3] <= accp_rd_q[i];
				end
				w_q <= accw_rd_q + 48'(vol_q);
			end
			ST_F_ACC: acc_q[j_q] <= acc_q[j_q] + 64'($signed(prod_q[63:16]));
			ST_N_LAT: begin
				for (int i = 0; i < 3; i++) begin
					acc_q[i]     <= accc_rd_q[i];
					acc_q[i + 3] <= accp_rd_q[i];
				end
				w_q <= accw_rd_q;
				c_q <= conc_rd_q;
			end
			ST_N_DIVS: begin
				dneg_q <= div_a[63];
				rem_q  <= div_mag[63:16];
				nlo_q  <= {div_mag[15:0], 16'd0};
				if (!w_pos) q_q <= '0;
				else if (div_ovf) q_q <= 32'h8000_0000;
				else q_q <= '0;
			end
			ST_N_DIV: begin
				rem_q <= r_ge ? r_diff[47:0] : r2[47:0];
				nlo_q <= {nlo_q[30:0], 1'b0};
				q_q   <= {q_q[30:0], r_ge};
			end
			ST_N_DIVE: gn_q[j_q] <= ssat(64'(q_q), dneg_q);
			ST_X_ZT: zt_q <= zt_d;
			ST_X_S: begin
				mag_q  <= s_d[53] ? 54'(-s_d) : 54'(s_d);
				spos_q <= !s_d[53] && (s_d != 54'sd0);
			end
			ST_X_FIN: fl_q[d_q] <= fin_d;
			ST_ACK: out_q <= '0;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> state_q == ST_IDLE)
		else $error("request taken while busy");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !out_valid_q)
		else $error("result pending during compute or read");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> out_valid_q && results.data.is_flux)
		else $error("read did not present a flux result");

	a_scatter_in_mesh: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_F_WR |-> 32'(nd_q) < 32'(nn_q))
		else $error("accumulator write outside mesh");

	a_div_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_N_DIV |-> div_cnt_q != 6'd0)
		else $error("divider ran past its last step");
`endif

endmodule
`default_nettype wire
